// ----- rtl/core/pate_pkg.sv -----
// Package for the packed array table engine: request codes, status codes and
// the command word broadcast to the row of table cells. No dependencies.
`timescale 1ns / 1ps

package pate_pkg;

   localparam int DATA_W = 32;

   // Request operation codes.
   localparam logic [2:0] OP_FIND   = 3'd0;
   localparam logic [2:0] OP_MODIFY = 3'd1;
   localparam logic [2:0] OP_APPEND = 3'd2;
   localparam logic [2:0] OP_REMOVE = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // Response status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // Command broadcast to every cell in the row.
   typedef struct packed {
      logic              cmp_en;    // capture a new match flag
      logic              by_pos;    // match on position instead of on the key
      logic              wr_en;     // write wdata into the addressed cell
      logic              shift_en;  // cells at or above the position, below the shift end, take their neighbor
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] wdata;
   } cell_cmd_type;

endpackage

// ----- rtl/core/pate_cell.sv -----
// One table cell: holds a single entry, compares it against the broadcast key
// or its own position, and can take its upper neighbor's entry. Uses pate_pkg.
`timescale 1ns / 1ps

module pate_cell
   import pate_pkg::*;
#(
   parameter int IW  = 7,
   parameter int IDX = 0
) (
   input  logic              clock,
   input  cell_cmd_type      cmd,
   input  logic [IW-1:0]     pos,
   input  logic [IW-1:0]     shift_end,
   input  logic [DATA_W-1:0] next_data,
   output logic [DATA_W-1:0] data,
   output logic              match
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              match_ff;
   logic              match_in;
   logic              at_pos;

   assign at_pos = (pos == IW'(IDX));

   // A direct write wins over a shift; only one is issued per request anyway.
   // Only cells from the removed position up to just below the last filled one
   // take their neighbor, so the old last entry and everything past it stay put.
   always_comb begin
      data_in = data_ff;
      if (cmd.wr_en && at_pos) begin
         data_in = cmd.wdata;
      end else if (cmd.shift_en && (IW'(IDX) >= pos) && (IW'(IDX) < shift_end)) begin
         data_in = next_data;
      end
   end

   // The match flag is held until the next compare.
   always_comb begin
      match_in = match_ff;
      if (cmd.cmp_en) begin
         match_in = cmd.by_pos ? at_pos : (data_ff == cmd.key);
      end
   end

   // Payload only, so no reset.
   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

// ----- rtl/core/pate_seek.sv -----
// Lowest-index search over the cell match flags: a radix-4 reduction tree that
// is folded onto one row of node registers, one level per cycle. Uses pate_pkg.
`timescale 1ns / 1ps

module pate_seek
   import pate_pkg::*;
#(
   parameter  int LEVELS = 4,
   localparam int SW     = 2 * LEVELS,
   localparam int LEAVES = 1 << SW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [LEAVES-1:0]     leaf_hit,
   input  logic [DATA_W-1:0]     leaf_data [LEAVES],
   output logic                  done,
   output logic                  found,
   output logic [SW-1:0]         found_idx,
   output logic [DATA_W-1:0]     found_data
);

   localparam int N      = LEAVES / 4;
   localparam int RW     = $clog2(LEVELS + 1);

   logic              hit_ff  [N];
   logic              hit_in  [N];
   logic [SW-1:0]     idx_ff  [N];
   logic [SW-1:0]     idx_in  [N];
   logic [DATA_W-1:0] dat_ff  [N];
   logic [DATA_W-1:0] dat_in  [N];
   logic              busy_ff;
   logic              busy_in;
   logic [RW-1:0]     rem_ff;
   logic [RW-1:0]     rem_in;
   logic              step;

   assign done = busy_ff && (rem_ff == '0);
   assign step = busy_ff && (rem_ff != '0);

   // First level reads the leaves; later levels fold node 4j..4j+3 into node j.
   // Nodes above the folded range are cleared so stale hits never come back.
   // Scanning from the top child down lets the lowest hit win.
   always_comb begin
      for (int j = 0; j < N; j++) begin
         hit_in[j] = hit_ff[j];
         idx_in[j] = idx_ff[j];
         dat_in[j] = dat_ff[j];
      end
      if (start) begin
         for (int j = 0; j < N; j++) begin
            hit_in[j] = 1'b0;
            idx_in[j] = '0;
            dat_in[j] = '0;
            for (int k = 3; k >= 0; k--) begin
               if (leaf_hit[4*j+k]) begin
                  hit_in[j] = 1'b1;
                  idx_in[j] = SW'(4*j+k);
                  dat_in[j] = leaf_data[4*j+k];
               end
            end
         end
      end else if (step) begin
         for (int j = 0; j < N; j++) begin
            hit_in[j] = 1'b0;
            idx_in[j] = '0;
            dat_in[j] = '0;
         end
         for (int j = 0; j < N / 4; j++) begin
            for (int k = 3; k >= 0; k--) begin
               if (hit_ff[4*j+k]) begin
                  hit_in[j] = 1'b1;
                  idx_in[j] = idx_ff[4*j+k];
                  dat_in[j] = dat_ff[4*j+k];
               end
            end
         end
      end
   end

   // Level counter.
   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = RW'(LEVELS - 1);
      end else if (step) begin
         rem_in = rem_ff - 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rem_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         rem_ff  <= rem_in;
      end
   end

   // Node payload needs no reset.
   always_ff @(posedge clock) begin
      for (int j = 0; j < N; j++) begin
         hit_ff[j] <= hit_in[j];
         idx_ff[j] <= idx_in[j];
         dat_ff[j] <= dat_in[j];
      end
   end

   assign found      = hit_ff[0];
   assign found_idx  = idx_ff[0];
   assign found_data = dat_ff[0];

endmodule

// ----- rtl/core/packed_array_table_engine_top.sv -----
// Find and in-range modify: the cells compare in S_EXEC, pate_seek then runs its
// LEVELS = ceil(log4(CAPACITY)) tree levels, and S_DONE loads the response once the
// response register is free; the next request is taken back in S_IDLE.
// All other operations: S_EXEC acts, then S_DONE loads the response; one request at a time.
// Synchronous reset empties the table (fill count zero); entries are not cleared.
// Top level of the packed array table engine. Uses pate_pkg, pate_cell, pate_seek.
`timescale 1ns / 1ps

module packed_array_table_engine_top
   import pate_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_op,
   input  logic [7:0]               req_index,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [6:0]               rsp_found_index,
   output logic signed [DATA_W-1:0] rsp_old_value,
   output logic [7:0]               rsp_fill_count
);

   localparam int IW     = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int LEVELS = (IW + 1) / 2;
   localparam int SW     = 2 * LEVELS;
   localparam int LEAVES = 1 << SW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_START,
      S_SEEK,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [2:0]        op_ff;
   logic [7:0]        index_ff;
   logic [DATA_W-1:0] value_ff;
   logic [CW-1:0]     count_ff;
   logic [1:0]        res_status_ff;
   logic [6:0]        res_where_ff;
   logic [DATA_W-1:0] res_old_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [6:0]        rsp_where_ff;
   logic [DATA_W-1:0] rsp_old_ff;
   logic [7:0]        rsp_fill_ff;

   cell_cmd_type      cmd;
   logic [IW-1:0]     pos;
   logic [IW-1:0]     shift_end;
   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_next [CAPACITY];
   logic [CAPACITY-1:0] cell_match;
   logic [LEAVES-1:0] leaf_hit;
   logic [DATA_W-1:0] leaf_data [LEAVES];

   logic              in_cap;
   logic              in_fill;
   logic              not_full;
   logic              rsp_free;
   logic              seek_start;
   logic              seek_done;
   logic              seek_found;
   logic [SW-1:0]     seek_idx;
   logic [DATA_W-1:0] seek_data;

   assign in_cap   = 32'(index_ff) < 32'(CAPACITY);
   assign in_fill  = 32'(index_ff) < 32'(count_ff);
   assign not_full = 32'(count_ff) < 32'(CAPACITY);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign seek_start = (state_ff == S_START);
   assign req_ready  = (state_ff == S_IDLE);

   // A remove shifts only the cells below the last filled position.
   assign shift_end = IW'(count_ff - 1'b1);

   // Command to the cell row for the current step of the request.
   always_comb begin
      cmd          = '0;
      cmd.key      = value_ff;
      cmd.wdata    = value_ff;
      pos          = IW'(index_ff);
      unique case (state_ff)
         S_EXEC: begin
            unique case (op_ff)
               OP_FIND: begin
                  cmd.cmp_en = 1'b1;
               end
               OP_MODIFY: begin
                  cmd.cmp_en = in_cap;
                  cmd.by_pos = 1'b1;
               end
               OP_APPEND: begin
                  cmd.wr_en = not_full;
                  pos       = IW'(count_ff);
               end
               OP_REMOVE: begin
                  cmd.shift_en = in_fill;
               end
               OP_CLEAR: begin
                  cmd.wr_en = in_fill;
                  cmd.wdata = '0;
               end
               default: begin
               end
            endcase
         end
         S_DONE: begin
            // Modify writes its new value once the old one has been read out.
            cmd.wr_en = rsp_free && (op_ff == OP_MODIFY) && in_cap;
         end
         default: begin
         end
      endcase
   end

   // Row of cells; cells in the shifted range take their upper neighbor on a remove.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == CAPACITY - 1) begin : g_last
         assign cell_next[i] = cell_data[i];
      end else begin : g_mid
         assign cell_next[i] = cell_data[i+1];
      end

      pate_cell #(
         .IW  (IW),
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .pos       (pos),
         .shift_end (shift_end),
         .next_data (cell_next[i]),
         .data      (cell_data[i]),
         .match     (cell_match[i])
      );
   end

   // Search leaves: a key match only counts inside the fill; padding never hits.
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < CAPACITY) begin : g_real
         assign leaf_hit[i]  = cell_match[i]
                               && ((op_ff == OP_MODIFY) || (32'(i) < 32'(count_ff)));
         assign leaf_data[i] = cell_data[i];
      end else begin : g_pad
         assign leaf_hit[i]  = 1'b0;
         assign leaf_data[i] = '0;
      end
   end

   pate_seek #(
      .LEVELS (LEVELS)
   ) u_seek (
      .clock      (clock),
      .reset      (reset),
      .start      (seek_start),
      .leaf_hit   (leaf_hit),
      .leaf_data  (leaf_data),
      .done       (seek_done),
      .found      (seek_found),
      .found_idx  (seek_idx),
      .found_data (seek_data)
   );

   // Request sequencer with the fill count and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A response taken while the next one is loaded is replaced in S_DONE.
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_op;
                  index_ff <= req_index;
                  value_ff <= req_value;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               res_where_ff <= '0;
               res_old_ff   <= '0;
               unique case (op_ff)
                  OP_FIND: begin
                     res_status_ff <= ST_OK;
                     state_ff      <= S_START;
                  end
                  OP_MODIFY: begin
                     if (in_cap) begin
                        res_status_ff <= ST_OK;
                        state_ff      <= S_START;
                     end else begin
                        res_status_ff <= ST_RANGE;
                        state_ff      <= S_DONE;
                     end
                  end
                  OP_APPEND: begin
                     state_ff <= S_DONE;
                     if (not_full) begin
                        count_ff      <= count_ff + 1'b1;
                        res_status_ff <= ST_OK;
                     end else begin
                        res_status_ff <= ST_FULL;
                     end
                  end
                  OP_REMOVE: begin
                     state_ff <= S_DONE;
                     if (in_fill) begin
                        count_ff      <= count_ff - 1'b1;
                        res_status_ff <= ST_OK;
                     end else begin
                        res_status_ff <= ST_RANGE;
                     end
                  end
                  OP_CLEAR: begin
                     state_ff      <= S_DONE;
                     res_status_ff <= in_fill ? ST_OK : ST_RANGE;
                  end
                  default: begin
                     state_ff      <= S_DONE;
                     res_status_ff <= ST_OK;
                  end
               endcase
            end
            S_START: begin
               state_ff <= S_SEEK;
            end
            S_SEEK: begin
               if (seek_done) begin
                  state_ff <= S_DONE;
                  if (op_ff == OP_FIND) begin
                     res_status_ff <= seek_found ? ST_OK : ST_NOT_FOUND;
                     res_where_ff  <= seek_found ? 7'(seek_idx) : 7'd0;
                  end else begin
                     res_old_ff <= seek_data;
                  end
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_where_ff  <= res_where_ff;
                  rsp_old_ff    <= res_old_ff;
                  rsp_fill_ff   <= 8'(count_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_where_ff;
   assign rsp_old_value   = rsp_old_ff;
   assign rsp_fill_count  = rsp_fill_ff;

   // The fill count never passes the table size.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY))
      else $error("fill count above capacity");

   // The search unit only finishes while the sequencer waits for it.
   a_seek_owner : assert property (@(posedge clock) disable iff (reset)
      seek_done |-> (state_ff == S_SEEK))
      else $error("search finished outside the search state");

   // A taken request always starts in the execute step.
   a_req_exec : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EXEC))
      else $error("request not executed after acceptance");

   // A modify that reaches the search always hits its own position.
   a_modify_hit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEEK && seek_done && op_ff == OP_MODIFY) |-> seek_found)
      else $error("modify position missing in search");

   // Leaving the final step always presents a response.
   a_rsp_load : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free) |=> rsp_valid_ff)
      else $error("response not loaded");

endmodule
